### hw/rtl/cic_pkg.sv
`timescale 1ns / 1ps
package cic_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int DATA_W      = 32;
    localparam int CFG_ORDER_W = 4;
    localparam int ORDER_W     = $clog2(MAX_ORDER + 1);
    localparam int IDX_W       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    localparam logic [CFG_ORDER_W-1:0] ORDER_RESET = CFG_ORDER_W'(3);

    localparam logic CMD_INTEGRATE = 1'b0;
    localparam logic CMD_COMB      = 1'b1;

    localparam int  PADDR_W          = 3;
    localparam logic REG_FILTER_ORDER = 1'b0;

    typedef struct packed {
        logic             load_sample;
        logic             integ_step;
        logic             comb_load;
        logic             comb_step;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } cic_cmd_t;

    function automatic logic [ORDER_W-1:0] active_order(input logic [CFG_ORDER_W-1:0] v);
        int unsigned n;
        n = v;
        if (n < 1) begin
            n = 1;
        end
        if (n > MAX_ORDER) begin
            n = MAX_ORDER;
        end
        return ORDER_W'(n);
    endfunction

endpackage

### hw/rtl/cic_datapath.sv
`timescale 1ns / 1ps
module cic_datapath
    import cic_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cic_cmd_t          cmd,
    input  logic [DATA_W-1:0] sample,
    output logic [DATA_W-1:0] result
);

    logic [DATA_W-1:0] integ_reg [MAX_ORDER];
    logic [DATA_W-1:0] comb_reg  [MAX_ORDER];
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] out_reg;
    logic [DATA_W-1:0] integ_rd;
    logic [DATA_W-1:0] comb_rd;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;

    assign integ_rd = integ_reg[cmd.idx];
    assign comb_rd  = comb_reg[cmd.idx];
    assign sum      = integ_rd + acc_reg;
    assign diff     = acc_reg - comb_rd;
    assign result   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                integ_reg[i] <= '0;
                comb_reg[i]  <= '0;
            end
        end else begin
            if (cmd.integ_step) begin
                integ_reg[cmd.idx] <= sum;
            end
            if (cmd.comb_step) begin
                comb_reg[cmd.idx] <= acc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            acc_reg <= sample;
        end else if (cmd.integ_step) begin
            acc_reg <= sum;
        end else if (cmd.comb_load) begin
            acc_reg <= integ_rd;
        end else if (cmd.comb_step) begin
            acc_reg <= diff;
        end
        if (cmd.out_load) begin
            out_reg <= diff;
        end
    end

endmodule

### hw/rtl/cic_ctrl.sv
`timescale 1ns / 1ps
module cic_ctrl
    import cic_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ORDER_W-1:0] order,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_command,
    output logic               m_tvalid,
    input  logic               m_tready,
    output cic_cmd_t           cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INTEG = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;
    localparam logic [1:0] ST_COMB  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [ORDER_W-1:0] order_m1;
    logic [IDX_W-1:0]   last_idx;
    logic               last;
    logic               out_free;

    assign order_m1 = order - 1'b1;
    assign last_idx = IDX_W'(order_m1);
    assign last     = (idx_reg == last_idx);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd              = '0;
        cmd.idx          = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_command == CMD_INTEGRATE) begin
                        cmd.load_sample = 1'b1;
                        idx_next        = '0;
                        state_next      = ST_INTEG;
                    end else begin
                        idx_next   = last_idx;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_INTEG: begin
                cmd.integ_step = 1'b1;
                idx_next       = idx_reg + 1'b1;
                if (last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                cmd.comb_load = 1'b1;
                idx_next      = '0;
                state_next    = ST_COMB;
            end
            ST_COMB: begin
                if (!last || out_free) begin
                    cmd.comb_step = 1'b1;
                    cmd.out_load  = last;
                    idx_next      = idx_reg + 1'b1;
                    if (last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### hw/rtl/cic_sinc_k_filter_top.sv
`timescale 1ns / 1ps
// CIC (sinc^k) filter with a run-time order of 1 to MAX_ORDER stages.
// Input stream: s_tuser carries the command (0 integrate, 1 comb), s_tdata
// the signed 32-bit sample. Integrate words produce nothing; each comb word
// produces one filtered word on the output stream (m_tdata). Decimation is
// set by how often comb words are sent.
// A 32-bit adder and a 32-bit subtractor walk the stages, one stage per
// cycle bar a stall in the last comb stage; n is the active order
// (filter_order clamped to 1..MAX_ORDER). Integrate: sample load, then
// n stages. Comb: load, n stages, result valid in the cycle after the last.
// One word is in work at a time; s_tready is high only between words.
// The result sits in an output register, so a new word is taken while it
// waits; a comb word that finishes while the previous result is still not
// taken holds in its last stage until m_tready frees the register.
// Users write filter_order at APB address 0 only while idle; not enforced.
// Reset (aresetn low, synchronous) clears all integrator and comb delay
// stages, drops m_tvalid and sets filter_order to 3.
module cic_sinc_k_filter_top
    import cic_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // [31:0] sample
    input  logic               s_tuser,   // [0] command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata    // [31:0] filtered_value
);

    logic [CFG_ORDER_W-1:0] order_reg, order_next;
    logic [ORDER_W-1:0]     order_act;
    logic                   cfg_wr;
    cic_cmd_t               cmd;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign order_act = active_order(order_reg);

    always_comb begin
        order_next = order_reg;
        if (cfg_wr && (paddr[2] == REG_FILTER_ORDER)) begin
            order_next = pwdata[CFG_ORDER_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_FILTER_ORDER) begin
            prdata = {{(32 - CFG_ORDER_W){1'b0}}, order_reg};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= ORDER_RESET;
        end else begin
            order_reg <= order_next;
        end
    end

    cic_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .order     (order_act),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    cic_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sample  (s_tdata),
        .result  (m_tdata)
    );

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_sample, cmd.integ_step, cmd.comb_load, cmd.comb_step}))
        else $error("more than one datapath operation at once");

    a_out_on_comb: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> cmd.comb_step)
        else $error("result loaded outside a comb step");

    a_integ_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_INTEGRATE) && !m_tvalid) |=> !m_tvalid)
        else $error("integrate word produced a result");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.integ_step || cmd.comb_load || cmd.comb_step) |-> !s_tready)
        else $error("input accepted while stages are walked");

endmodule
